### rtl/assert_macros.svh
// Assertion macros used by the controller of the RSA exponentiation RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on aclk, quiet during reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, quiet during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rme_pkg.sv
// Package: types, constants and codes of the RSA modular exponentiation block
package rme_pkg;

    localparam int MOD_WIDTH_DEF  = 32;
    localparam int DATA_WIDTH     = 32;
    localparam int EXP_WIDTH      = 32;
    localparam int EXP_CNT_W      = $clog2(EXP_WIDTH);
    localparam int APB_ADDR_WIDTH = 4;
    localparam int APB_DATA_WIDTH = 32;

    // register indexes (byte address / 4)
    localparam logic [1:0] REG_MODULUS     = 2'd0;
    localparam logic [1:0] REG_PUBLIC_EXP  = 2'd1;
    localparam logic [1:0] REG_PRIVATE_EXP = 2'd2;
    localparam logic [1:0] REG_PRIVATE_EN  = 2'd3;

    // opcodes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    typedef struct packed {
        logic                  opcode;
        logic [DATA_WIDTH-1:0] data_value;
    } in_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] result_value;
        logic                  denied;
    } out_item_t;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] modulus;
        logic [EXP_WIDTH-1:0]  public_exponent;
        logic [EXP_WIDTH-1:0]  private_exponent;
        logic                  private_enabled;
    } cfg_t;

    typedef enum logic [1:0] {
        MUL_REDUCE,
        MUL_SQUARE,
        MUL_MULT
    } mul_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REDUCE,
        ST_SQUARE,
        ST_MULT,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic     load;
        logic     mul_start;
        mul_sel_t mul_sel;
        logic     exp_shift;
        logic     out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic mul_busy;
        logic exp_msb;
        logic exp_last;
        logic special;
    } dp_status_t;

endpackage

### rtl/rsa_modular_exponentiation.sv
// Top level of the RSA modular exponentiation block
//
// Computes data_value^e mod n for one item at a time. Software first writes
// the modulus, the public and private exponents and the private-key enable
// over the APB port (byte addresses 0, 4, 8, 12), only while the block is idle.
// Items arrive on the s_ valid/ready channel: opcode encrypt uses the public
// exponent, decrypt the private one. Decrypt without the enable set returns
// zero with denied raised. Each item yields exactly one result on m_.
// The power is done by square-and-multiply over all 32 exponent bits with a
// bit-serial interleaved modular multiplier. Exponent zero, modulus zero and
// denied items skip the multiplier and go straight to the result register.
// One item is processed at a time. The finished result sits in an output
// register: the next item is accepted while it waits, and a stalled receiver
// only holds the block in its final step once the next result is ready.
// Reset (aresetn low, synchronous) empties the output, returns the sequencer
// to idle and restores the register defaults.
module rsa_modular_exponentiation #(
    parameter int MOD_WIDTH = rme_pkg::MOD_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rme_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [rme_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [rme_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                               pready,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  rme_pkg::in_item_t                  s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output rme_pkg::out_item_t                 m_data
);
    import rme_pkg::*;

    cfg_t       cfg;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    rme_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rme_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rme_datapath #(
        .MOD_WIDTH (MOD_WIDTH)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_data  (m_data)
    );

endmodule

### rtl/rme_apb_regs.sv
// APB configuration registers of the RSA modular exponentiation block
module rme_apb_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rme_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [rme_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic [rme_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                               pready,
    output rme_pkg::cfg_t                      cfg
);
    import rme_pkg::*;

    cfg_t cfg_reg, cfg_next;
    logic wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[APB_ADDR_WIDTH-1:2];

    // write decode
    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_MODULUS:     cfg_next.modulus          = pwdata;
                REG_PUBLIC_EXP:  cfg_next.public_exponent  = pwdata;
                REG_PRIVATE_EXP: cfg_next.private_exponent = pwdata;
                REG_PRIVATE_EN:  cfg_next.private_enabled  = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (reg_idx)
            REG_MODULUS:     prdata = cfg_reg.modulus;
            REG_PUBLIC_EXP:  prdata = cfg_reg.public_exponent;
            REG_PRIVATE_EXP: prdata = cfg_reg.private_exponent;
            REG_PRIVATE_EN:  prdata = APB_DATA_WIDTH'(cfg_reg.private_enabled);
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.modulus          <= DATA_WIDTH'(2);
            cfg_reg.public_exponent  <= '0;
            cfg_reg.private_exponent <= '0;
            cfg_reg.private_enabled  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/rme_datapath.sv
// Datapath: exponent scanner, bit-serial modular multiplier and result register
module rme_datapath #(
    parameter int MOD_WIDTH = rme_pkg::MOD_WIDTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  rme_pkg::cfg_t       cfg,
    input  rme_pkg::in_item_t   s_data,
    input  rme_pkg::ctrl_cmd_t  cmd,
    output rme_pkg::dp_status_t status,
    output rme_pkg::out_item_t  m_data
);
    import rme_pkg::*;

    localparam int CNT_W = (MOD_WIDTH > 1) ? $clog2(MOD_WIDTH) : 1;

    logic [MOD_WIDTH-1:0] m_val;
    logic [MOD_WIDTH-1:0] acc_reg, acc_next;
    logic [MOD_WIDTH-1:0] base_reg, base_next;
    logic [MOD_WIDTH-1:0] a_reg, a_next;
    logic [MOD_WIDTH-1:0] b_reg, b_next;
    logic [MOD_WIDTH-1:0] r_reg, r_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 dest_base_reg, dest_base_next;
    logic [EXP_WIDTH-1:0] exp_reg, exp_next;
    logic [EXP_CNT_W-1:0] exp_cnt_reg, exp_cnt_next;
    logic                 deny_reg, deny_next;
    logic                 mzero_reg, mzero_next;
    logic                 ezero_reg, ezero_next;
    out_item_t            out_reg, out_next;

    logic [MOD_WIDTH:0]   dbl, dbl_sub, sum, sum_sub;
    logic [MOD_WIDTH-1:0] dbl_red, step_r;
    logic [EXP_WIDTH-1:0] exp_sel;

    assign m_val = cfg.modulus[MOD_WIDTH-1:0];

    // one multiplier step: r = 2r mod m, then r = r + a mod m when the b bit is set
    always_comb begin
        dbl     = {r_reg, 1'b0};
        dbl_sub = dbl - {1'b0, m_val};
        dbl_red = (dbl >= {1'b0, m_val}) ? dbl_sub[MOD_WIDTH-1:0] : dbl[MOD_WIDTH-1:0];
        sum     = {1'b0, dbl_red} + {1'b0, a_reg};
        sum_sub = sum - {1'b0, m_val};
        if (!b_reg[MOD_WIDTH-1]) begin
            step_r = dbl_red;
        end else if (sum >= {1'b0, m_val}) begin
            step_r = sum_sub[MOD_WIDTH-1:0];
        end else begin
            step_r = sum[MOD_WIDTH-1:0];
        end
    end

    assign exp_sel = (s_data.opcode == OP_DECRYPT) ? cfg.private_exponent
                                                   : cfg.public_exponent;

    // next-state of all datapath registers
    always_comb begin
        acc_next       = acc_reg;
        base_next      = base_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        busy_next      = busy_reg;
        dest_base_next = dest_base_reg;
        exp_next       = exp_reg;
        exp_cnt_next   = exp_cnt_reg;
        deny_next      = deny_reg;
        mzero_next     = mzero_reg;
        ezero_next     = ezero_reg;
        out_next       = out_reg;

        // capture the item and classify the special cases
        if (cmd.load) begin
            acc_next     = MOD_WIDTH'(1);
            base_next    = s_data.data_value[MOD_WIDTH-1:0];
            exp_next     = exp_sel;
            exp_cnt_next = EXP_CNT_W'(EXP_WIDTH - 1);
            deny_next    = (s_data.opcode == OP_DECRYPT) && !cfg.private_enabled;
            mzero_next   = (m_val == '0);
            ezero_next   = (exp_sel == '0);
        end

        if (cmd.exp_shift) begin
            exp_next     = {exp_reg[EXP_WIDTH-2:0], 1'b0};
            exp_cnt_next = exp_cnt_reg - EXP_CNT_W'(1);
        end

        // operand selection at multiplier start
        if (cmd.mul_start) begin
            busy_next = 1'b1;
            r_next    = '0;
            cnt_next  = CNT_W'(MOD_WIDTH - 1);
            case (cmd.mul_sel)
                MUL_REDUCE: begin
                    a_next         = MOD_WIDTH'(1);
                    b_next         = base_reg;
                    dest_base_next = 1'b1;
                end
                MUL_SQUARE: begin
                    a_next         = acc_reg;
                    b_next         = acc_reg;
                    dest_base_next = 1'b0;
                end
                MUL_MULT: begin
                    a_next         = acc_reg;
                    b_next         = base_reg;
                    dest_base_next = 1'b0;
                end
                default: begin
                    a_next         = acc_reg;
                    b_next         = acc_reg;
                    dest_base_next = 1'b0;
                end
            endcase
        end else if (busy_reg) begin
            r_next   = step_r;
            b_next   = b_reg << 1;
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                if (dest_base_reg) begin
                    base_next = step_r;
                end else begin
                    acc_next = step_r;
                end
            end
        end

        // result register
        if (cmd.out_load) begin
            out_next.denied = deny_reg;
            if (deny_reg || mzero_reg) begin
                out_next.result_value = '0;
            end else if (ezero_reg) begin
                out_next.result_value = DATA_WIDTH'(1);
            end else begin
                out_next.result_value = DATA_WIDTH'(acc_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg       <= acc_next;
        base_reg      <= base_next;
        a_reg         <= a_next;
        b_reg         <= b_next;
        r_reg         <= r_next;
        cnt_reg       <= cnt_next;
        dest_base_reg <= dest_base_next;
        exp_reg       <= exp_next;
        exp_cnt_reg   <= exp_cnt_next;
        deny_reg      <= deny_next;
        mzero_reg     <= mzero_next;
        ezero_reg     <= ezero_next;
        out_reg       <= out_next;
    end

    assign status.mul_busy = busy_reg;
    assign status.exp_msb  = exp_reg[EXP_WIDTH-1];
    assign status.exp_last = (exp_cnt_reg == '0);
    assign status.special  = deny_reg | mzero_reg | ezero_reg;
    assign m_data          = out_reg;

endmodule

### rtl/rme_ctrl.sv
// Controller: sequences reduction, squarings and multiplications, owns the handshakes
`include "assert_macros.svh"
module rme_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  rme_pkg::dp_status_t status,
    output rme_pkg::ctrl_cmd_t  cmd
);
    import rme_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.special) begin
                    state_next = ST_FINISH;
                end else begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_REDUCE;
                    state_next    = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (!status.mul_busy) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sel   = MUL_SQUARE;
                    state_next    = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (!status.mul_busy) begin
                    if (status.exp_msb) begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_sel   = MUL_MULT;
                        state_next    = ST_MULT;
                    end else if (status.exp_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.exp_shift = 1'b1;
                        cmd.mul_start = 1'b1;
                        cmd.mul_sel   = MUL_SQUARE;
                    end
                end
            end
            ST_MULT: begin
                if (!status.mul_busy) begin
                    if (status.exp_last) begin
                        state_next = ST_FINISH;
                    end else begin
                        cmd.exp_shift = 1'b1;
                        cmd.mul_start = 1'b1;
                        cmd.mul_sel   = MUL_SQUARE;
                        state_next    = ST_SQUARE;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output slot: filled on load, emptied on transfer
    assign m_valid_next = cmd.out_load | (m_valid_reg & ~m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

    `ASSERT_IMPLIES(a_out_slot_free, cmd.out_load, !m_valid_reg || m_ready, "result overwritten")
    `ASSERT_NEXT(a_accept_closes, s_valid && s_ready, !s_ready, "second item taken while busy")
    `ASSERT_IMPLIES(a_idle_quiet, state_reg == ST_IDLE, !status.mul_busy, "multiplier busy in idle")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the RSA modular exponentiation block
`timescale 1ns / 1ps

module tb_top;
    import rme_pkg::*;

    localparam int MOD_W       = MOD_WIDTH_DEF;
    localparam int QUIET_LIMIT = 20000;   // longest item plus the long hold-off, with margin
    localparam int HOLD_AT     = 40;      // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES = 5000;
    localparam int RAND_PHASES = 5;
    localparam int RAND_ITEMS  = 55;
    localparam logic [31:0] WIDTH_MASK = (MOD_W >= 32) ? 32'hFFFF_FFFF : ((32'd1 << MOD_W) - 1);

    logic                      aclk    = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      psel    = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite  = 1'b0;
    logic [APB_ADDR_WIDTH-1:0] paddr   = '0;
    logic [APB_DATA_WIDTH-1:0] pwdata  = '0;
    logic [APB_DATA_WIDTH-1:0] prdata;
    logic                      pready;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    in_item_t                  s_data  = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    out_item_t                 m_data;

    // Key copy held by the testbench, updated at each register write
    logic [31:0] key_modulus  = 32'd2;
    logic [31:0] key_public   = 32'd0;
    logic [31:0] key_private  = 32'd0;
    logic        key_priv_en  = 1'b0;

    in_item_t  items_to_send[$];
    out_item_t expected_powers[$];
    out_item_t want_res;

    int errors          = 0;
    int items_accepted  = 0;
    int results_checked = 0;
    int encrypts        = 0;
    int decrypts        = 0;
    int refusals        = 0;
    int key_settings    = 0;
    int send_gap        = 0;
    int send_calm       = 0;
    int recv_stall      = 0;
    int recv_calm       = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;
    int quiet_cycles    = 0;

    rsa_modular_exponentiation DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #10 aclk = ~aclk;

    // Square-and-multiply from the top exponent bit, 64-bit products
    function automatic logic [31:0] mod_pow(logic [31:0] base, logic [31:0] expo,
                                            logic [31:0] n);
        logic [63:0] acc;
        logic [63:0] b;
        int          k;
        if (n == 32'd0) return 32'd0;
        if (expo == 32'd0) return 32'd1;
        b   = base % n;
        acc = 64'd1;
        for (k = 31; k >= 0; k--) begin
            acc = (acc * acc) % n;
            if (expo[k]) acc = (acc * b) % n;
        end
        return acc[31:0];
    endfunction

    function automatic out_item_t predict_power(in_item_t it);
        out_item_t r;
        r.denied = 1'b0;
        if (it.opcode == OP_ENCRYPT) begin
            r.result_value = mod_pow(it.data_value & WIDTH_MASK, key_public,
                                     key_modulus & WIDTH_MASK);
        end else if (key_priv_en) begin
            r.result_value = mod_pow(it.data_value & WIDTH_MASK, key_private,
                                     key_modulus & WIDTH_MASK);
        end else begin
            r.result_value = 32'd0;
            r.denied       = 1'b1;
        end
        return r;
    endfunction

    // Mostly short gaps, a few long, and occasional runs with none
    function automatic int draw_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 25);
        return $urandom_range(60, 300);
    endfunction

    // Sender: offers queued items, holds payload until the transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_powers.push_back(predict_power(s_data));
                items_accepted++;
                if (s_data.opcode == OP_ENCRYPT) encrypts++;
                else decrypts++;
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (items_to_send.size() != 0) begin
                    s_valid  <= 1'b1;
                    s_data   <= items_to_send.pop_front();
                    send_gap = draw_gap(send_calm);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each transfer against the oldest prediction
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_powers.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result value %h denied %b", $time,
                             m_data.result_value, m_data.denied);
                end else begin
                    want_res = expected_powers.pop_front();
                    if (m_data.result_value !== want_res.result_value) begin
                        errors++;
                        $display("%0t: result_value expected %h actual %h", $time,
                                 want_res.result_value, m_data.result_value);
                    end
                    if (m_data.denied !== want_res.denied) begin
                        errors++;
                        $display("%0t: denied expected %b actual %b", $time,
                                 want_res.denied, m_data.denied);
                    end
                    if (want_res.denied) refusals++;
                    results_checked++;
                end
                recv_stall = draw_gap(recv_calm);
            end else if (!m_valid && recv_stall == 0 && $urandom_range(0, 199) == 0) begin
                recv_stall = draw_gap(recv_calm) + 1;
            end
            // long hold-off so the block fills and stalls its input
            if (!hold_done && results_checked == HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge aclk) begin
        if (!aresetn || psel || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // APB write: setup then access, register taken at the access edge
    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MODULUS:     key_modulus = val;
            REG_PUBLIC_EXP:  key_public  = val;
            REG_PRIVATE_EXP: key_private = val;
            REG_PRIVATE_EN:  key_priv_en = val[0];
            default: ;
        endcase
    endtask

    task automatic set_key(logic [31:0] n, logic [31:0] e, logic [31:0] d, logic en);
        write_reg(REG_MODULUS, n);
        write_reg(REG_PUBLIC_EXP, e);
        write_reg(REG_PRIVATE_EXP, d);
        write_reg(REG_PRIVATE_EN, {31'd0, en});
        key_settings++;
        @(negedge aclk);
    endtask

    task automatic send(logic op, logic [31:0] val);
        in_item_t it;
        it.opcode     = op;
        it.data_value = val;
        items_to_send.push_back(it);
    endtask

    // Wait until every item has gone in and every result has come out;
    // checked mid-cycle so the sender's last offer is already visible
    task automatic drain();
        while (items_to_send.size() != 0 || s_valid || expected_powers.size() != 0)
            @(negedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    function automatic logic [31:0] random_modulus();
        int r;
        r = $urandom_range(0, 99);
        if (r < 3) return 32'd0;
        if (r < 6) return 32'd1;
        if (r < 9) return 32'd2;
        if (r < 14) return 32'hFFFF_FFFF;
        if (r < 40) return $urandom_range(3, 65535);
        return $urandom;
    endfunction

    function automatic logic [31:0] random_exponent();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 32'd0;
        if (r < 30) return $urandom_range(1, 255);
        if (r < 38) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [31:0] random_base();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 32'd0;
        if (r < 8) return 32'hFFFF_FFFF;
        if (r < 11) return key_modulus;
        if (r < 14) return key_modulus - 32'd1;
        return $urandom;
    endfunction

    initial begin
        int p;
        int i;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset key: modulus 2, zero exponents, decrypt refused
        send(OP_ENCRYPT, 32'h0000_0000);
        send(OP_ENCRYPT, 32'hFFFF_FFFF);
        send(OP_DECRYPT, 32'h0000_0005);
        drain();

        // Small textbook key
        set_key(32'd3233, 32'd17, 32'd2753, 1'b1);
        send(OP_ENCRYPT, 32'h0000_0000);
        send(OP_ENCRYPT, 32'h0000_0001);
        send(OP_ENCRYPT, 32'd65);
        send(OP_ENCRYPT, 32'hFFFF_FFFF);
        send(OP_ENCRYPT, 32'h8000_0000);
        send(OP_DECRYPT, 32'd2790);
        send(OP_DECRYPT, 32'h0000_0000);
        send(OP_DECRYPT, 32'hFFFF_FFFF);
        drain();

        // All-ones modulus and exponents: slowest items
        set_key(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send(OP_ENCRYPT, 32'hFFFF_FFFF);
        send(OP_ENCRYPT, 32'hFFFF_FFFE);
        send(OP_DECRYPT, 32'h0000_0002);
        drain();

        // Modulus one: nonzero exponent gives zero, zero exponent gives one
        set_key(32'd1, 32'd5, 32'd0, 1'b1);
        send(OP_ENCRYPT, 32'd7);
        send(OP_DECRYPT, 32'd7);
        drain();

        // Modulus zero, and decrypt refused again
        set_key(32'd0, 32'd3, 32'd3, 1'b0);
        send(OP_ENCRYPT, 32'd9);
        send(OP_DECRYPT, 32'd9);
        drain();

        // Random keys with random items
        for (p = 0; p < RAND_PHASES; p++) begin
            set_key(random_modulus(), random_exponent(), random_exponent(),
                    $urandom_range(0, 3) != 0);
            for (i = 0; i < RAND_ITEMS; i++)
                send($urandom_range(0, 1) ? OP_DECRYPT : OP_ENCRYPT, random_base());
            drain();
        end

        repeat (20) @(posedge aclk);
        $display("Covered %0d items (%0d encrypt, %0d decrypt) over %0d key settings;",
                 items_accepted, encrypts, decrypts, key_settings + 1);
        $display("%0d results checked, %0d refused, %0d mismatches.",
                 results_checked, refusals, errors);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
